/* rtl/rgbr_pkg.sv */
// shared types and constants for the rounded gradient bar rasteriser
// no dependencies
package rgbr_pkg;

    localparam int SAMPLES = 4;
    localparam logic [4:0] HITS_FULL = 5'd16;

    localparam logic [2:0] REG_BAR_WIDTH       = 3'd0;
    localparam logic [2:0] REG_BAR_HEIGHT      = 3'd1;
    localparam logic [2:0] REG_CORNER_RADIUS   = 3'd2;
    localparam logic [2:0] REG_TOP_COLOUR      = 3'd3;
    localparam logic [2:0] REG_BASE_COLOUR     = 3'd4;
    localparam logic [2:0] REG_HAIRLINE_COLOUR = 3'd5;

    typedef struct packed {
        logic [12:0] bar_width;
        logic [6:0]  bar_height;
        logic [5:0]  corner_radius;
        logic [23:0] top_colour;
        logic [23:0] base_colour;
        logic [23:0] hairline_colour;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLES-1:0][8:0] mag_x;
        logic [SAMPLES-1:0][8:0] mag_y;
        logic [17:0]             rr;
        logic                    corner;
        logic                    outside;
        logic                    hair;
        logic [2:0][14:0]        num;
        logic [6:0]              hm1;
    } t_s1;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_en;

endpackage

/* rtl/rgbr_regs.sv */
// configuration register file behind the apb-style port
// depends on rgbr_pkg
module rgbr_regs
    import rgbr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bar_width       <= 13'd1024;
            r_cfg.bar_height      <= 7'd32;
            r_cfg.corner_radius   <= 6'd8;
            r_cfg.top_colour      <= '0;
            r_cfg.base_colour     <= '0;
            r_cfg.hairline_colour <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (idx)
                REG_BAR_WIDTH:       r_cfg.bar_width       <= pwdata[12:0];
                REG_BAR_HEIGHT:      r_cfg.bar_height      <= pwdata[6:0];
                REG_CORNER_RADIUS:   r_cfg.corner_radius   <= pwdata[5:0];
                REG_TOP_COLOUR:      r_cfg.top_colour      <= pwdata[23:0];
                REG_BASE_COLOUR:     r_cfg.base_colour     <= pwdata[23:0];
                REG_HAIRLINE_COLOUR: r_cfg.hairline_colour <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_BAR_WIDTH:       prdata = {19'd0, r_cfg.bar_width};
            REG_BAR_HEIGHT:      prdata = {25'd0, r_cfg.bar_height};
            REG_CORNER_RADIUS:   prdata = {26'd0, r_cfg.corner_radius};
            REG_TOP_COLOUR:      prdata = {8'd0, r_cfg.top_colour};
            REG_BASE_COLOUR:     prdata = {8'd0, r_cfg.base_colour};
            REG_HAIRLINE_COLOUR: prdata = {8'd0, r_cfg.hairline_colour};
            default:             prdata = '0;
        endcase
    end

endmodule

/* rtl/rgbr_setup.sv */
// first pipeline stage: bounds, corner decode, sample offsets, blend numerators
// depends on rgbr_pkg
module rgbr_setup
    import rgbr_pkg::*;
#(
    parameter int MAX_BAR_WIDTH  = 4096,
    parameter int MAX_BAR_HEIGHT = 64
) (
    input  logic        i_clk,
    input  t_cfg        i_cfg,
    input  t_en         i_en,
    input  logic [11:0] i_pixel_x,
    input  logic [5:0]  i_pixel_y,
    output t_s1         o_s1
);

    t_s1 r_s1;
    t_s1 n_s1;

    logic [12:0] w;
    logic [6:0]  h;
    logic [6:0]  hm1;
    logic [5:0]  r;
    logic [12:0] x_plus_r;
    logic        left;
    logic        right;
    logic [5:0]  dx_off;
    logic [5:0]  dy_off;
    logic [6:0]  up;

    assign w = (32'(i_cfg.bar_width) > MAX_BAR_WIDTH) ? 13'(MAX_BAR_WIDTH) : i_cfg.bar_width;
    assign h = (32'(i_cfg.bar_height) > MAX_BAR_HEIGHT) ? 7'(MAX_BAR_HEIGHT)
                                                        : i_cfg.bar_height;
    assign hm1 = h - 7'd1;
    assign r   = i_cfg.corner_radius;
    assign x_plus_r = {1'b0, i_pixel_x} + {7'd0, r};
    assign left   = (i_pixel_x < {6'd0, r});
    assign right  = !left && (x_plus_r > w);
    assign dx_off = left ? (r - i_pixel_x[5:0]) : 6'(x_plus_r - w);
    assign dy_off = r - i_pixel_y;
    assign up     = hm1 - {1'b0, i_pixel_y};

    always_comb begin
        n_s1.outside = ({1'b0, i_pixel_x} >= w) || ({1'b0, i_pixel_y} >= h);
        n_s1.hair    = ({1'b0, i_pixel_y} == hm1);
        n_s1.corner  = (i_pixel_y < r) && (left || right);
        n_s1.rr      = {12'(r) * 12'(r), 6'd0};
        n_s1.hm1     = hm1;
        for (int i = 0; i < SAMPLES; i++) begin
            if (left) begin
                n_s1.mag_x[i] = {dx_off, 3'd0} - 9'(2 * i + 1);
            end else begin
                n_s1.mag_x[i] = {dx_off, 3'd0} + 9'(2 * i + 1);
            end
            n_s1.mag_y[i] = {dy_off, 3'd0} - 9'(2 * i + 1);
        end
        for (int c = 0; c < 3; c++) begin
            n_s1.num[c] = 15'(16'(i_cfg.base_colour[8*c +: 8]) * 16'(i_pixel_y)
                            + 16'(i_cfg.top_colour[8*c +: 8]) * 16'(up));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

/* rtl/rgbr_cover.sv */
// stages two and three of the coverage path: sample squares, disc test, hit count
// depends on rgbr_pkg
module rgbr_cover
    import rgbr_pkg::*;
(
    input  logic       i_clk,
    input  t_en        i_en,
    input  t_s1        i_s1,
    output logic [4:0] o_hits
);

    logic [17:0] r_sq_x [SAMPLES];
    logic [17:0] r_sq_y [SAMPLES];
    logic [17:0] r_rr;
    logic        r_corner;
    logic [4:0]  r_hits;
    logic [SAMPLES*SAMPLES-1:0] hit_vec;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int i = 0; i < SAMPLES; i++) begin
                r_sq_x[i] <= 18'(i_s1.mag_x[i]) * 18'(i_s1.mag_x[i]);
                r_sq_y[i] <= 18'(i_s1.mag_y[i]) * 18'(i_s1.mag_y[i]);
            end
            r_rr     <= i_s1.rr;
            r_corner <= i_s1.corner;
        end
    end

    always_comb begin
        for (int j = 0; j < SAMPLES; j++) begin
            for (int i = 0; i < SAMPLES; i++) begin
                hit_vec[j*SAMPLES + i] = ({1'b0, r_sq_x[i]} + {1'b0, r_sq_y[j]})
                                         <= {1'b0, r_rr};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_hits <= r_corner ? 5'($countones(hit_vec)) : HITS_FULL;
        end
    end

    assign o_hits = r_hits;

endmodule

/* rtl/rgbr_blend.sv */
// stages two and three of the gradient path: restoring divide by height minus one
// depends on rgbr_pkg
module rgbr_blend
    import rgbr_pkg::*;
(
    input  logic            i_clk,
    input  t_en             i_en,
    input  t_s1             i_s1,
    output logic [2:0][7:0] o_colour
);

    logic [2:0][14:0] r_rem;
    logic [2:0][3:0]  r_qh;
    logic [6:0]       r_hm1;
    logic [2:0][7:0]  r_q;
    logic [2:0][14:0] n_rem;
    logic [2:0][3:0]  n_qh;
    logic [2:0][14:0] n_rem2;
    logic [2:0][7:0]  n_q;

    // upper quotient nibble
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_rem[c] = i_s1.num[c];
            n_qh[c]  = '0;
            for (int k = 0; k < 4; k++) begin
                if (n_rem[c] >= (15'(i_s1.hm1) << (7 - k))) begin
                    n_rem[c] = n_rem[c] - (15'(i_s1.hm1) << (7 - k));
                    n_qh[c]  = {n_qh[c][2:0], 1'b1};
                end else begin
                    n_qh[c]  = {n_qh[c][2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_rem <= n_rem;
            r_qh  <= n_qh;
            r_hm1 <= i_s1.hm1;
        end
    end

    // lower quotient nibble
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_rem2[c] = r_rem[c];
            n_q[c]    = {4'd0, r_qh[c]};
            for (int k = 0; k < 4; k++) begin
                if (n_rem2[c] >= (15'(r_hm1) << (3 - k))) begin
                    n_rem2[c] = n_rem2[c] - (15'(r_hm1) << (3 - k));
                    n_q[c]    = {n_q[c][6:0], 1'b1};
                end else begin
                    n_q[c]    = {n_q[c][6:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_q <= n_q;
        end
    end

    assign o_colour = r_q;

endmodule

/* rtl/rounded_gradient_bar_rasterizer_core.sv */
// Pixel generator for a title bar with a vertical gradient, a hairline bottom
// row and antialiased rounded top corners. Unless the output stalls, it takes one
// pixel word per clock and returns one premultiplied ARGB word per clock, through
// four register stages (setup and blend numerators, sample squares with the upper
// quotient bits, disc test with the lower quotient bits, coverage scaling into the
// output register). Registers must be written over the APB-style port only while
// no pixel is in flight; the block itself does not enforce this.
// depends on rgbr_pkg, rgbr_regs, rgbr_setup, rgbr_cover, rgbr_blend
module rounded_gradient_bar_rasterizer_core
    import rgbr_pkg::*;
#(
    parameter int MAX_BAR_WIDTH  = 4096,
    parameter int MAX_BAR_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_x[11:0], pixel_y[17:12], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // alpha[7:0], red[15:8], green[23:16], blue[31:24]
);

    t_cfg cfg;
    t_s1  s1;
    t_en  en;

    logic r_v1, r_v2, r_v3, r_v4;
    logic r_out2, r_hair2, r_out3, r_hair3;
    logic [31:0] r_tdata;
    logic [4:0]  hits;
    logic [2:0][7:0] blend;
    logic [2:0][7:0] colour;
    logic [31:0] n_tdata;
    logic [12:0] prod_a;
    logic [2:0][12:0] prod_c;

    assign en.s4 = !r_v4 || m_axis_tready;
    assign en.s3 = !r_v3 || en.s4;
    assign en.s2 = !r_v2 || en.s3;
    assign en.s1 = !r_v1 || en.s2;

    assign s_axis_tready = en.s1;
    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = r_tdata;

    rgbr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rgbr_setup #(
        .MAX_BAR_WIDTH  (MAX_BAR_WIDTH),
        .MAX_BAR_HEIGHT (MAX_BAR_HEIGHT)
    ) u_setup (
        .i_clk     (i_clk),
        .i_cfg     (cfg),
        .i_en      (en),
        .i_pixel_x (s_axis_tdata[11:0]),
        .i_pixel_y (s_axis_tdata[17:12]),
        .o_s1      (s1)
    );

    rgbr_cover u_cover (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_s1   (s1),
        .o_hits (hits)
    );

    rgbr_blend u_blend (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_s1     (s1),
        .o_colour (blend)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= s_axis_tvalid;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2;
            if (en.s4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s2) begin
            r_out2  <= s1.outside;
            r_hair2 <= s1.hair;
        end
        if (en.s3) begin
            r_out3  <= r_out2;
            r_hair3 <= r_hair2;
        end
        if (en.s4) begin
            r_tdata <= n_tdata;
        end
    end

    // coverage scaling, half up
    always_comb begin
        prod_a = 13'(hits) * 13'd255 + 13'd8;
        for (int c = 0; c < 3; c++) begin
            colour[c] = r_hair3 ? cfg.hairline_colour[8*c +: 8] : blend[c];
            prod_c[c] = 13'(colour[c]) * 13'(hits) + 13'd8;
        end
        if (r_out3) begin
            n_tdata = '0;
        end else begin
            n_tdata = {prod_c[0][11:4], prod_c[1][11:4], prod_c[2][11:4], prod_a[11:4]};
        end
    end

    a_zero_alpha_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[7:0] == 8'd0) |-> m_axis_tdata[31:8] == 24'd0)
        else $error("zero coverage with non-zero colour");

    a_premultiplied : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:8] <= m_axis_tdata[7:0])
                       && (m_axis_tdata[23:16] <= m_axis_tdata[7:0])
                       && (m_axis_tdata[31:24] <= m_axis_tdata[7:0]))
        else $error("channel exceeds alpha");

    a_entry_from_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v1) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("stage one filled without an accepted word");

    a_stage3_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !en.s4) |=> r_v3)
        else $error("stalled stage three lost its word");

endmodule
